FILE: src/jdjc_pkg.sv
// Shared types and constants of the job dispatcher.
package jdjc_pkg;
    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int NUM_SLOTS_DEF   = 16;

    typedef enum logic [2:0] {
        CMD_SUBMIT = 3'd0,
        CMD_OPEN   = 3'd1,
        CMD_CHILD  = 3'd2,
        CMD_POP    = 3'd3,
        CMD_DONE   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOSLT = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  worker_index;
        logic [31:0] job_handle;
        logic [3:0]  slot_in;
        logic        slot_valid;
        logic [15:0] child_count;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] job_out;
        logic [3:0]  slot_out;
        logic        has_parent;
        logic [2:0]  chosen_queue;
        logic        parent_released;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_EXEC, S_READ, S_PUSH, S_OUT
    } t_state;
endpackage

FILE: src/jdjc_if.sv
// Valid/ready channel interfaces for requests and responses.
interface jdjc_req_if;
    import jdjc_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface jdjc_rsp_if;
    import jdjc_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/job_dispatcher_with_join_counters.sv
// Top level of the job dispatcher with join counters.
//  channel   dir  handshake     payload
//  i_req     in   valid/ready   cmd, worker_index, job_handle, slot_in, slot_valid, child_count
//  o_rsp     out  valid/ready   status, job_out, slot_out, has_parent, chosen_queue, parent_released
//  i_cfg_we  in   write enable  i_cfg_data = active_queues
// A submit scans the queues compared by the dispatch scan (up to NUM_QUEUES) and then
// pushes; an open-group searches the slots; a pop checks the fill, reads the queue memory
// and then returns the entry; a completion decrements the join counter and, when it
// releases a parent, pushes the parent. One command is in flight at a time.
// Reset is synchronous and clears pointers, fills and slot busy bits.
// A stalled response holds the block; a new beat is taken once the response leaves.
module job_dispatcher_with_join_counters #(
    parameter int NUM_QUEUES  = jdjc_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = jdjc_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_SLOTS   = jdjc_pkg::NUM_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    jdjc_req_if.sink   i_req,
    jdjc_rsp_if.source o_rsp
);
    import jdjc_pkg::*;

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int DW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + NUM_QUEUES + 1);

    t_state r_state, n_state;
    t_req   r_req;
    t_rsp   r_rsp, n_rsp;
    logic [3:0] r_active;
    logic [DW-1:0] r_head [NUM_QUEUES];
    logic [DW-1:0] r_tail [NUM_QUEUES];
    logic [FW-1:0] r_fill [NUM_QUEUES];
    logic [NUM_SLOTS-1:0] r_busy;
    logic [15:0] r_pend [NUM_SLOTS];
    logic [31:0] r_par [NUM_SLOTS];
    logic [36:0] r_mem [NUM_QUEUES*QUEUE_DEPTH];
    logic [36:0] r_rd;
    logic [CW-1:0] r_idx;
    logic [QW-1:0] r_q;
    logic [31:0] r_push_h;
    logic [3:0]  r_push_s;
    logic        r_push_p;

    logic [4:0] eff_n;
    logic [QW-1:0] worker, i_q, nx_q;
    logic [4:0] nx5;
    logic [15:0] cnt_dec;
    logic slot_hit;

    // The worker index is below 8, so a few compare-and-subtract steps wrap it.
    function automatic logic [2:0] wrap_worker(input logic [2:0] w);
        logic [2:0] v;
        v = w;
        for (int k = 0; k < 8; k++) begin
            if (32'(v) >= NUM_QUEUES) v = v - 3'(NUM_QUEUES);
        end
        return v;
    endfunction

    always_comb begin
        if (r_active == 4'd0) eff_n = 5'd1;
        else if (32'(r_active) > NUM_QUEUES) eff_n = 5'(NUM_QUEUES);
        else eff_n = {1'b0, r_active};
    end

    assign worker = QW'(wrap_worker(r_req.worker_index));
    assign i_q    = r_idx[QW-1:0];
    assign nx5    = (5'(r_idx) + 5'd1 >= eff_n) ? 5'd0 : 5'(r_idx) + 5'd1;
    assign nx_q   = nx5[QW-1:0];
    assign slot_hit = r_req.slot_valid && (32'(r_req.slot_in) < NUM_SLOTS)
                      && r_busy[r_req.slot_in[SW-1:0]]
                      && (r_pend[r_req.slot_in[SW-1:0]] != 16'd0);
    assign cnt_dec = r_pend[r_req.slot_in[SW-1:0]] - 16'd1;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.data  = r_rsp;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_SCAN;
            S_SCAN: begin
                case (r_req.cmd)
                    CMD_SUBMIT, CMD_CHILD: begin
                        if (r_fill[i_q] <= r_fill[nx_q] || 5'(r_idx) + 5'd1 >= eff_n)
                            n_state = S_PUSH;
                    end
                    CMD_OPEN: begin
                        if (!r_busy[r_idx[SW-1:0]] || 32'(r_idx) + 1 >= NUM_SLOTS)
                            n_state = S_OUT;
                    end
                    CMD_POP: n_state = (r_fill[worker] == '0) ? S_OUT : S_READ;
                    CMD_DONE: n_state = (slot_hit && cnt_dec == 16'd0) ? S_PUSH : S_OUT;
                    default: n_state = S_OUT;
                endcase
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: n_state = S_OUT;
            S_PUSH: n_state = S_OUT;
            S_OUT:  if (o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Response contents.
    always_comb begin
        n_rsp = r_rsp;
        unique case (r_state)
            S_IDLE: n_rsp = '0;
            S_SCAN: begin
                case (r_req.cmd)
                    CMD_OPEN: begin
                        if (!r_busy[r_idx[SW-1:0]]) begin
                            n_rsp.status   = ST_OK;
                            n_rsp.slot_out = 4'(r_idx);
                        end else if (32'(r_idx) + 1 >= NUM_SLOTS) begin
                            n_rsp.status = ST_NOSLT;
                        end
                    end
                    CMD_POP: if (r_fill[worker] == '0) n_rsp.status = ST_EMPTY;
                    default: ;
                endcase
            end
            S_EXEC: begin
                n_rsp.job_out    = r_rd[36:5];
                n_rsp.slot_out   = r_rd[4:1];
                n_rsp.has_parent = r_rd[0];
            end
            S_PUSH: begin
                n_rsp.chosen_queue = 3'(r_q);
                if (32'(r_fill[r_q]) >= QUEUE_DEPTH) n_rsp.status = ST_FULL;
                else if (r_req.cmd == CMD_DONE) n_rsp.parent_released = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 4'd8;
            r_busy   <= '0;
            for (int k = 0; k < NUM_QUEUES; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_fill[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_active <= i_cfg_data;
            case (r_state)
                S_SCAN: begin
                    if (r_req.cmd == CMD_OPEN && !r_busy[r_idx[SW-1:0]]) begin
                        r_busy[r_idx[SW-1:0]] <= 1'b1;
                    end
                    if (r_req.cmd == CMD_DONE && slot_hit && cnt_dec == 16'd0) begin
                        r_busy[r_req.slot_in[SW-1:0]] <= 1'b0;
                    end
                end
                S_READ: begin
                    r_head[worker] <= (32'(r_head[worker]) + 1 >= QUEUE_DEPTH)
                                      ? '0 : r_head[worker] + DW'(1);
                    r_fill[worker] <= r_fill[worker] - FW'(1);
                end
                S_PUSH: begin
                    if (32'(r_fill[r_q]) < QUEUE_DEPTH) begin
                        r_tail[r_q] <= (32'(r_tail[r_q]) + 1 >= QUEUE_DEPTH)
                                       ? '0 : r_tail[r_q] + DW'(1);
                        r_fill[r_q] <= r_fill[r_q] + FW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers and memories.
    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (r_state == S_IDLE) begin
            r_req <= i_req.data;
            r_idx <= '0;
            r_q   <= '0;
        end
        if (r_state == S_SCAN) begin
            r_idx <= r_idx + CW'(1);
            case (r_req.cmd)
                CMD_SUBMIT, CMD_CHILD: begin
                    if (!(r_fill[i_q] <= r_fill[nx_q]) && 5'(r_idx) + 5'd1 >= eff_n)
                        r_q <= '0;
                    else
                        r_q <= i_q;
                    r_push_h <= r_req.job_handle;
                    r_push_s <= r_req.slot_in;
                    r_push_p <= (r_req.cmd == CMD_CHILD);
                end
                CMD_OPEN: begin
                    if (!r_busy[r_idx[SW-1:0]]) begin
                        r_par[r_idx[SW-1:0]]  <= r_req.job_handle;
                        r_pend[r_idx[SW-1:0]] <= r_req.child_count;
                    end
                end
                CMD_DONE: begin
                    if (slot_hit) r_pend[r_req.slot_in[SW-1:0]] <= cnt_dec;
                    r_q      <= worker;
                    r_push_h <= r_par[r_req.slot_in[SW-1:0]];
                    r_push_s <= 4'd0;
                    r_push_p <= 1'b0;
                end
                default: ;
            endcase
        end
        if (r_state == S_READ) begin
            r_rd <= r_mem[32'(worker) * QUEUE_DEPTH + 32'(r_head[worker])];
        end
        if (r_state == S_PUSH && 32'(r_fill[r_q]) < QUEUE_DEPTH) begin
            r_mem[32'(r_q) * QUEUE_DEPTH + 32'(r_tail[r_q])] <= {r_push_h, r_push_s, r_push_p};
        end
    end
endmodule
